### hw/rtl/ccpi_pkg.sv
// Shared constants and types for the cruise control PI regulator.
package ccpi_pkg;

    localparam int SPEED_W    = 8;
    localparam int GAIN_W     = 4;
    localparam int LEVEL_W    = 7;
    localparam int SUM_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN         = 3'd0,
        CFG_ENGAGE_MIN_SPEED  = 3'd1,
        CFG_FULL_THROTTLE_TOP = 3'd2,
        CFG_FULL_THROTTLE_LOW = 3'd3,
        CFG_THROTTLE_MAX      = 3'd4
    } cfg_idx_t;

    // Register values after reset.
    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST         = 4'd3;
    localparam logic [LEVEL_W-1:0] ENGAGE_MIN_SPEED_RST  = 7'd20;
    localparam logic [LEVEL_W-1:0] FULL_THROTTLE_TOP_RST = 7'd80;
    localparam logic [LEVEL_W-1:0] FULL_THROTTLE_LOW_RST = 7'd40;
    localparam logic [LEVEL_W-1:0] THROTTLE_MAX_RST      = 7'd80;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 16'sh7FFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 16'sh8000;

endpackage

### hw/rtl/cruise_control_pi_regulator_unit.sv
// Top level of the cruise control PI regulator: input stage, PI step and result stage.
//
// Usage: each control tick is one beat on the item channel (item_valid/item_ready)
// carrying the signed speed and the pedal, gear, engine and cruise-button levels.
// Every item produces exactly one result beat on the result channel
// (result_valid/result_ready) with throttle, engine_on, target_speed,
// cruise_active and gas_override.
// On acceptance the item is written into the input register; when it advances,
// its result is written into the result register, which presents the result beat.
// Throughput is one item per cycle while the receiver keeps result_ready high;
// the PI step, including the cruise state update, is one short combinational
// pass between the two registers, so a new tick sees the state left by the
// previous one.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more item; after that item_ready drops.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; writes to indexes above the register list are dropped, and only the
// low bits a register needs are kept. Configure only while the block is idle.
// Reset (rst_n low, asynchronous) disengages cruise, clears the target and the
// integral, empties both stages and loads the default register values.
module cruise_control_pi_regulator_unit
    import ccpi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Item channel
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [SPEED_W-1:0]    speed,
    input  logic                  gas_pressed,
    input  logic                  brake_pressed,
    input  logic                  in_top_gear,
    input  logic                  engine_switch,
    input  logic                  cruise_button,
    // Result channel
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [LEVEL_W-1:0]    throttle,
    output logic                  engine_on,
    output logic [LEVEL_W-1:0]    target_speed,
    output logic                  cruise_active,
    output logic                  gas_override,
    // Configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic [GAIN_W-1:0]  prop_gain_reg;
    logic [LEVEL_W-1:0] engage_min_speed_reg;
    logic [LEVEL_W-1:0] full_throttle_top_reg;
    logic [LEVEL_W-1:0] full_throttle_low_reg;
    logic [LEVEL_W-1:0] throttle_max_reg;

    // Cruise state.
    logic                    engaged_reg;
    logic [LEVEL_W-1:0]      target_reg;
    logic signed [SUM_W-1:0] error_sum_reg;

    // Input stage.
    logic               s1_valid_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic               gas_reg;
    logic               brake_reg;
    logic               top_reg;
    logic               eng_sw_reg;
    logic               button_reg;

    // Result stage.
    logic               result_valid_reg;
    logic [LEVEL_W-1:0] throttle_reg;
    logic               engine_on_reg;
    logic [LEVEL_W-1:0] target_speed_reg;
    logic               cruise_active_reg;
    logic               gas_override_reg;

    logic advance;

    // The input stage moves on when the result register is empty or being drained.
    assign advance    = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    // ---------------------------------------------------------------------
    // Configuration writes.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg         <= PROP_GAIN_RST;
            engage_min_speed_reg  <= ENGAGE_MIN_SPEED_RST;
            full_throttle_top_reg <= FULL_THROTTLE_TOP_RST;
            full_throttle_low_reg <= FULL_THROTTLE_LOW_RST;
            throttle_max_reg      <= THROTTLE_MAX_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN:         prop_gain_reg         <= cfg_data[GAIN_W-1:0];
                CFG_ENGAGE_MIN_SPEED:  engage_min_speed_reg  <= cfg_data;
                CFG_FULL_THROTTLE_TOP: full_throttle_top_reg <= cfg_data;
                CFG_FULL_THROTTLE_LOW: full_throttle_low_reg <= cfg_data;
                CFG_THROTTLE_MAX:      throttle_max_reg      <= cfg_data;
                default:               ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Input register.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            speed_reg  <= speed;
            gas_reg    <= gas_pressed;
            brake_reg  <= brake_pressed;
            top_reg    <= in_top_gear;
            eng_sw_reg <= engine_switch;
            button_reg <= cruise_button;
        end
    end

    // ---------------------------------------------------------------------
    // PI step on the registered item.
    // ---------------------------------------------------------------------
    logic                    engaged_eff;
    logic [LEVEL_W-1:0]      target_eff;
    logic                    speed_ok;
    logic                    hold;
    logic                    engine_on_c;
    logic signed [9:0]       err;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic signed [13:0]      prod;
    logic signed [17:0]      pi_wide;
    logic [LEVEL_W-1:0]      pi_throttle;
    logic [LEVEL_W-1:0]      throttle_c;
    logic                    override_c;

    logic                    engaged_next;
    logic [LEVEL_W-1:0]      target_next;
    logic signed [SUM_W-1:0] error_sum_next;

    always_comb
    begin
        // A press of the cruise button while disengaged latches the current speed.
        engaged_eff = engaged_reg || button_reg;
        target_eff  = engaged_reg ? target_reg : speed_reg[LEVEL_W-1:0];

        speed_ok = $signed({speed_reg[SPEED_W-1], speed_reg})
                   >= $signed({2'b00, engage_min_speed_reg});
        hold     = top_reg && speed_ok && !gas_reg && !brake_reg && engaged_eff;

        engine_on_c = eng_sw_reg || (!speed_reg[SPEED_W-1] && (speed_reg != '0));

        // Speed error and saturating integral.
        err      = $signed({3'b000, target_eff})
                   - $signed({speed_reg[SPEED_W-1], speed_reg[SPEED_W-1], speed_reg});
        sum_wide = $signed({error_sum_reg[SUM_W-1], error_sum_reg})
                   + $signed({{7{err[9]}}, err});
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end

        // Proportional term plus integral, clamped to 0 through throttle_max.
        prod    = $signed({10'd0, prop_gain_reg}) * $signed({{4{err[9]}}, err});
        pi_wide = $signed({{4{prod[13]}}, prod}) + $signed({{2{sum_sat[SUM_W-1]}}, sum_sat});
        if (pi_wide[17])
        begin
            pi_throttle = '0;
        end
        else if (pi_wide > $signed({11'd0, throttle_max_reg}))
        begin
            pi_throttle = throttle_max_reg;
        end
        else
        begin
            pi_throttle = pi_wide[LEVEL_W-1:0];
        end

        if (hold)
        begin
            engaged_next   = 1'b1;
            target_next    = target_eff;
            error_sum_next = sum_sat;
            throttle_c     = pi_throttle;
        end
        else
        begin
            engaged_next   = 1'b0;
            target_next    = '0;
            error_sum_next = '0;
            throttle_c     = '0;
        end

        // The gas pedal overrides with the gear's full throttle, not clamped.
        override_c = gas_reg && engine_on_c;
        if (override_c)
        begin
            throttle_c = top_reg ? full_throttle_top_reg : full_throttle_low_reg;
        end
    end

    // Cruise state follows each item as it leaves the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            engaged_reg   <= 1'b0;
            target_reg    <= '0;
            error_sum_reg <= '0;
        end
        else if (advance)
        begin
            engaged_reg   <= engaged_next;
            target_reg    <= target_next;
            error_sum_reg <= error_sum_next;
        end
    end

    // ---------------------------------------------------------------------
    // Result register.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            throttle_reg      <= throttle_c;
            engine_on_reg     <= engine_on_c;
            target_speed_reg  <= target_next;
            cruise_active_reg <= hold;
            gas_override_reg  <= override_c;
        end
    end

    assign result_valid  = result_valid_reg;
    assign throttle      = throttle_reg;
    assign engine_on     = engine_on_reg;
    assign target_speed  = target_speed_reg;
    assign cruise_active = cruise_active_reg;
    assign gas_override  = gas_override_reg;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------

    // The PI law and the gas override never both drive one beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(cruise_active && gas_override))
        else $error("cruise_active and gas_override both set");

    // A nonzero target is only reported while the PI law runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (target_speed != '0)) |-> cruise_active)
        else $error("target_speed reported while cruise inactive");

    // An item that keeps cruise engaged leaves the engaged state set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && hold) |=> engaged_reg)
        else $error("engaged state lost after an active tick");

    // A tick that drops cruise clears the integral and the target.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !hold) |=> (error_sum_reg == '0) && (target_reg == '0))
        else $error("integral or target not cleared on disengage");

endmodule
